>>> hw/rtl/wlsel_pkg.sv
// Shared types and constants for the weighted lottery selector.
// Used by the controller, the datapath and the top level.
package wlsel_pkg;

	localparam int CFG_W     = 4;
	localparam int OUT_IDX_W = 4;
	localparam int IN_IDX_W  = 4;
	localparam int IN_WGT_W  = 9;
	localparam int RND_W     = 31;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_W-1:0]     COUNT_RESET = 4'd15;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = DIV_CNT_W'(RND_W - 1);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CHECK,
		ST_DIV,
		ST_FIND,
		ST_EMIT_NONE,
		ST_EMIT_HIT
	} wlsel_state_t;

	typedef struct packed {
		logic wr_en;
		logic load;
		logic scan_clr;
		logic scan_run;
		logic find_mode;
		logic div_init;
		logic div_step;
		logic out_load;
		logic out_none;
	} wlsel_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic hit;
		logic total_zero;
		logic div_last;
		logic out_free;
	} wlsel_status_t;

endpackage

>>> hw/rtl/wlsel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wlsel_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/wlsel_ctrl.sv
// Controller state machine of the weighted lottery selector.
// Depends on wlsel_pkg; drives commands to wlsel_datapath.
module wlsel_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     req_type,
	output logic                     in_stall,
	input  wlsel_pkg::wlsel_status_t st,
	output wlsel_pkg::wlsel_cmd_t    cmd
);

	import wlsel_pkg::*;

	wlsel_state_t state_q;
	wlsel_state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_IDLE: begin
				if (in_valid && (req_type == REQ_SELECT)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (st.scan_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = st.total_zero ? ST_EMIT_NONE : ST_DIV;
			end
			ST_DIV: begin
				if (st.div_last) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (st.hit) begin
					state_d = ST_EMIT_HIT;
				end
			end
			ST_EMIT_NONE, ST_EMIT_HIT: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_en    = in_valid && (req_type == REQ_WRITE);
				cmd.load     = in_valid && (req_type == REQ_SELECT);
				cmd.scan_clr = in_valid && (req_type == REQ_SELECT);
			end
			ST_SUM: begin
				cmd.scan_run = 1'b1;
			end
			ST_CHECK: begin
				cmd.div_init = !st.total_zero;
				cmd.scan_clr = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FIND: begin
				cmd.scan_run  = 1'b1;
				cmd.find_mode = 1'b1;
			end
			ST_EMIT_NONE: begin
				cmd.out_load = st.out_free;
				cmd.out_none = 1'b1;
			end
			ST_EMIT_HIT: begin
				cmd.out_load = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> hw/rtl/wlsel_datapath.sv
// Datapath: entry table, weight sum, iterative remainder, winner scan, output register.
// Depends on wlsel_pkg and wlsel_ram; controlled by wlsel_ctrl.
module wlsel_datapath #(
	parameter int MAX_ENTRIES = 16,
	parameter int WEIGHT_BITS = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wlsel_pkg::wlsel_cmd_t                 cmd,
	output wlsel_pkg::wlsel_status_t              st,
	input  logic                                  cfg_we,
	input  logic [wlsel_pkg::CFG_W-1:0]           cfg_data,
	input  logic [wlsel_pkg::IN_IDX_W-1:0]        entry_index,
	input  logic                                  entry_enable,
	input  logic [wlsel_pkg::IN_WGT_W-1:0]        entry_weight,
	input  logic [wlsel_pkg::RND_W-1:0]           random_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [wlsel_pkg::OUT_IDX_W-1:0]       chosen_index,
	output logic                                  any_active
);

	import wlsel_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int LW    = (IDX_W > 4) ? IDX_W : 4;
	localparam int SUM_W = WEIGHT_BITS + IDX_W;
	localparam logic [LW-1:0] MAX_IDX = LW'(MAX_ENTRIES - 1);

	logic [CFG_W-1:0]       count_q;
	logic [MAX_ENTRIES-1:0] enable_q;
	logic [IDX_W-1:0]       rd_addr_q;
	logic                   issue_done_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [SUM_W-1:0]       total_q;
	logic [SUM_W-1:0]       run_q;
	logic [SUM_W-1:0]       rem_q;
	logic [RND_W-1:0]       rnd_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [LW-1:0]          found_q;
	logic                   out_valid_q;
	logic [OUT_IDX_W-1:0]   chosen_q;
	logic                   any_q;

	logic [LW-1:0]          count_ext;
	logic [LW-1:0]          last_ext;
	logic [IDX_W-1:0]       last_idx;
	logic                   wr_in_range;
	logic                   rd_en;
	logic [WEIGHT_BITS-1:0] rdata;
	logic                   proc;
	logic                   cur_en;
	logic [SUM_W-1:0]       add_w;
	logic [SUM_W-1:0]       run_next;
	logic [SUM_W:0]         div_t;
	logic                   div_ge;

	assign count_ext   = LW'(count_q);
	assign last_ext    = (count_ext > MAX_IDX) ? MAX_IDX : count_ext;
	assign last_idx    = last_ext[IDX_W-1:0];
	assign wr_in_range = (LW'(entry_index) <= MAX_IDX);
	assign rd_en       = cmd.scan_run && !issue_done_q;

	wlsel_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_weight_ram (
		.clk   (clk),
		.we    (cmd.wr_en && wr_in_range),
		.waddr (IDX_W'(entry_index)),
		.wdata (WEIGHT_BITS'(entry_weight)),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign proc     = cmd.scan_run && rd_valid_s1;
	assign cur_en   = enable_q[idx_s1];
	assign add_w    = cur_en ? SUM_W'(rdata) : '0;
	assign run_next = run_q + add_w;
	assign div_t    = {rem_q, rnd_q[RND_W-1]};
	assign div_ge   = (div_t >= {1'b0, total_q});

	assign st.scan_last  = proc && (idx_s1 == last_idx);
	assign st.hit        = proc && cmd.find_mode && cur_en && (rem_q < run_next);
	assign st.total_zero = (total_q == '0);
	assign st.div_last   = (div_cnt_q == '0);
	assign st.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= COUNT_RESET;
			enable_q     <= '0;
			issue_done_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.wr_en && wr_in_range) begin
				enable_q[IDX_W'(entry_index)] <= entry_enable;
			end
			if (cmd.scan_clr) begin
				issue_done_q <= 1'b0;
				rd_valid_s1  <= 1'b0;
			end else if (cmd.scan_run) begin
				rd_valid_s1 <= rd_en;
				if (rd_en && (rd_addr_q == last_idx)) begin
					issue_done_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rnd_q   <= random_value;
			total_q <= '0;
		end
		if (cmd.scan_clr) begin
			rd_addr_q <= '0;
			run_q     <= '0;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (rd_en) begin
			idx_s1 <= rd_addr_q;
		end
		if (proc) begin
			if (cmd.find_mode) begin
				run_q <= run_next;
			end else begin
				total_q <= total_q + add_w;
			end
		end
		if (st.hit) begin
			found_q <= LW'(idx_s1);
		end
		if (cmd.div_init) begin
			rem_q     <= '0;
			div_cnt_q <= DIV_LAST_BIT;
		end else if (cmd.div_step) begin
			rem_q     <= div_ge ? SUM_W'(div_t - {1'b0, total_q}) : SUM_W'(div_t);
			rnd_q     <= {rnd_q[RND_W-2:0], 1'b0};
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			chosen_q <= cmd.out_none ? OUT_IDX_W'(count_q) : found_q[OUT_IDX_W-1:0];
			any_q    <= !cmd.out_none;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = chosen_q;
	assign any_active   = any_q;

endmodule

>>> hw/rtl/weighted_lottery_selector.sv
// Top level of the weighted lottery selector.
// Depends on wlsel_pkg, wlsel_ctrl, wlsel_datapath and wlsel_ram.
//
// A write request (req_type 0) stores one entry's enable bit and weight; it gives no result.
// A select request (req_type 1) makes one pass over weight RAM entries 0 to L, where L is
// min(entry_count, MAX_ENTRIES-1), to form the sum, then a 31-bit restoring remainder of
// random_value by that sum, and a second RAM pass that stops at the winner (no remainder or
// second pass when the sum is zero). The weight RAM has a single read port and the
// remainder unit yields one bit per cycle; one select is worked on at a time. The result
// waits in an output register, so new writes are taken while it is stalled.
// Configuration is always ready.
module weighted_lottery_selector #(
	parameter int MAX_ENTRIES = 16,
	parameter int WEIGHT_BITS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wlsel_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [wlsel_pkg::IN_IDX_W-1:0]    entry_index,
	input  logic                              entry_enable,
	input  logic [wlsel_pkg::IN_WGT_W-1:0]    entry_weight,
	input  logic [wlsel_pkg::RND_W-1:0]       random_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wlsel_pkg::OUT_IDX_W-1:0]   chosen_index,
	output logic                              any_active
);

	import wlsel_pkg::*;

	wlsel_cmd_t    cmd;
	wlsel_status_t st;

	assign cfg_ready = 1'b1;

	wlsel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	wlsel_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.entry_enable (entry_enable),
		.entry_weight (entry_weight),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chosen_index (chosen_index),
		.any_active   (any_active)
	);

endmodule

>>> bench/weighted_lottery_selector_tb.sv
`timescale 1ns / 1ps
// Testbench for weighted_lottery_selector: directed and random table writes and draws,
// checked against an in-bench draw predictor. Needs wlsel_pkg and the selector RTL.
module weighted_lottery_selector_tb;
	import wlsel_pkg::*;

	localparam int TABLE_DEPTH     = 16;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int SETTLE_CYCLES   = 80;
	localparam int IDLE_LIMIT      = 2000;
	// entry_count per phase, phase 0 in the low nibble
	localparam logic [PHASES*CFG_W-1:0] PHASE_COUNTS =
		{4'd15, 4'd14, 4'd5, 4'd15, 4'd1, 4'd9, 4'd0, 4'd15};

	typedef struct {
		logic [OUT_IDX_W-1:0] winner;
		logic                 active;
	} pick_t;

	class lottery_board;
		logic                enables [TABLE_DEPTH];
		logic [IN_WGT_W-1:0] weights [TABLE_DEPTH];
		logic [CFG_W-1:0]    count;
		pick_t               pending_picks [$];
		int                  mismatches;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				enables[i] = 1'b0;
				weights[i] = IN_WGT_W'(1);
			end
			count = COUNT_RESET;
			mismatches = 0;
		endfunction

		function void set_count(logic [CFG_W-1:0] value);
			count = value;
		endfunction

		function pick_t draw(logic [RND_W-1:0] rnd);
			int unsigned total;
			int unsigned run;
			int unsigned rem;
			int          last;
			int          i;
			pick_t       p;
			last = (count > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(count);
			total = 0;
			for (i = 0; i <= last; i++)
				if (enables[i])
					total += weights[i];
			p.winner = OUT_IDX_W'(count);
			p.active = (total != 0);
			if (total != 0) begin
				rem = rnd % total;
				run = 0;
				for (i = 0; i <= last; i++) begin
					if (enables[i]) begin
						run += weights[i];
						if (rem < run) begin
							p.winner = OUT_IDX_W'(i);
							break;
						end
					end
				end
			end
			return p;
		endfunction

		function void note_request(logic req, logic [IN_IDX_W-1:0] idx, logic en,
				logic [IN_WGT_W-1:0] wgt, logic [RND_W-1:0] rnd);
			if (req == REQ_WRITE) begin
				if (idx < TABLE_DEPTH) begin
					enables[idx] = en;
					weights[idx] = wgt;
				end
			end else begin
				pending_picks.push_back(draw(rnd));
			end
		endfunction

		task log_mismatch(string msg);
			mismatches++;
			$display("%0t MISMATCH: %s", $realtime, msg);
		endtask

		task check_pick(logic [OUT_IDX_W-1:0] winner, logic active);
			pick_t want;
			if (pending_picks.size() == 0) begin
				log_mismatch($sformatf("unexpected result index %0d active %0b", winner, active));
			end else begin
				want = pending_picks.pop_front();
				if (winner !== want.winner)
					log_mismatch($sformatf("chosen_index %0d, want %0d", winner, want.winner));
				if (active !== want.active)
					log_mismatch($sformatf("any_active %0b, want %0b", active, want.active));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 req_type;
	logic [IN_IDX_W-1:0]  entry_index;
	logic                 entry_enable;
	logic [IN_WGT_W-1:0]  entry_weight;
	logic [RND_W-1:0]     random_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [OUT_IDX_W-1:0] chosen_index;
	logic                 any_active;

	lottery_board board;
	int           idle_pct = 0;
	int           quiet_cycles = 0;
	int           stall_left = 0;

	weighted_lottery_selector #(
		.MAX_ENTRIES(TABLE_DEPTH),
		.WEIGHT_BITS(IN_WGT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.entry_index(entry_index),
		.entry_enable(entry_enable),
		.entry_weight(entry_weight),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_index(chosen_index),
		.any_active(any_active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result check, watchdog and receiver stall bursts
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_pick(chosen_index, any_active);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(4, 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task send(input logic req, input logic [IN_IDX_W-1:0] idx, input logic en,
			input logic [IN_WGT_W-1:0] wgt, input logic [RND_W-1:0] rnd);
		in_valid     <= 1'b1;
		req_type     <= req;
		entry_index  <= idx;
		entry_enable <= en;
		entry_weight <= wgt;
		random_value <= rnd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(req, idx, en, wgt, rnd);
	endtask

	task sender_gap();
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(5, 1))
				@(posedge clk);
		end
	endtask

	task send_random();
		logic [RND_W-1:0]    rnd;
		logic [IN_WGT_W-1:0] wgt;
		logic                req;
		rnd = RND_W'($urandom);
		case ($urandom_range(7))
			0: rnd = '0;
			1: rnd = '1;
			2, 3: ;
			default: rnd = RND_W'($urandom_range(4095));
		endcase
		wgt = IN_WGT_W'($urandom);
		case ($urandom_range(7))
			0: wgt = '0;
			1: wgt = '1;
			2, 3: ;
			default: wgt = IN_WGT_W'($urandom_range(15, 1));
		endcase
		req = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_SELECT;
		send(req, IN_IDX_W'($urandom), $urandom_range(3) != 0, wgt, rnd);
		sender_gap();
	endtask

	// stop sending, let every pending draw come back, then let the block go idle
	task settle();
		in_valid <= 1'b0;
		while (board.pending_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task write_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_count(value);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int ph;
		int n;
		board        = new();
		arst_n       = 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		req_type     <= REQ_WRITE;
		entry_index  <= '0;
		entry_enable <= 1'b0;
		entry_weight <= '0;
		random_value <= '0;
		out_stall    <= 1'b0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, zero-weight entry, extremes of weight and random value
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd0);
		send(REQ_WRITE, 4'd0, 1'b1, 9'd0, 31'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'h7FFFFFFF);
		send(REQ_WRITE, 4'd15, 1'b1, 9'd511, 31'd0);
		send(REQ_SELECT, 4'd15, 1'b1, 9'd511, 31'h7FFFFFFF);
		send(REQ_WRITE, 4'd3, 1'b1, 9'd1, 31'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd1);
		send(REQ_WRITE, 4'd7, 1'b0, 9'd511, 31'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd511);
		send(REQ_WRITE, 4'd8, 1'b1, 9'h155, 31'h2AAAAAAA);
		send(REQ_SELECT, 4'd5, 1'b1, 9'h0AA, 31'h2AAAAAAA);
		send(REQ_SELECT, 4'd10, 1'b0, 9'h155, 31'h55555555);
		send(REQ_WRITE, 4'd10, 1'b1, 9'h0AA, 31'h55555555);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd1000);

		// only entry 0 takes part: zero weight first, then weight one
		settle();
		write_count(4'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'd123);
		send(REQ_WRITE, 4'd0, 1'b1, 9'd1, 31'd0);
		send(REQ_SELECT, 4'd0, 1'b0, 9'd0, 31'h7FFFFFFF);

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			write_count(PHASE_COUNTS[ph*CFG_W +: CFG_W]);
			idle_pct = (ph == PHASES - 1) ? 0 : (ph % 3) * 20;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 3 && n == 40)
					settle();
				send_random();
			end
		end
		settle();

		if (board.mismatches == 0 && board.pending_picks.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
